// ----- rtl/core/pit_pkg.sv -----
// Shared types and constants for the pending-interest table block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package pit_pkg;

   typedef enum logic [1:0] {
      CMD_INTEREST = 2'd0,
      CMD_DATA     = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_UNKNOWN  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_AGGREGATED = 3'd0,
      ACT_FORWARDED  = 3'd1,
      ACT_LOCAL      = 3'd2,
      ACT_NO_ROUTE   = 3'd3,
      ACT_DELIVERED  = 3'd4,
      ACT_UNSOLICIT  = 3'd5,
      ACT_TICK       = 3'd6,
      ACT_FULL       = 3'd7
   } act_type;

   localparam logic [1:0] CSR_LOCAL_ID = 2'd0;
   localparam logic [1:0] CSR_DEF_MASK = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT  = 2'd2;

   typedef struct packed {
      cmd_type     command;
      logic [15:0] content_id;
      logic [2:0]  arrival_face;
      logic        from_local;
   } pit_req_type;

   typedef struct packed {
      act_type     action;
      logic [7:0]  face_mask;
      logic        local_deliver;
   } pit_rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] content;
      logic [7:0]  faces;
      logic        local_flag;
      logic [15:0] stamp;
   } pit_entry_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic clear;
      logic load;
      logic rd;
      logic finish;
   } pit_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
   } pit_stat_type;

endpackage

// ----- rtl/core/pit_ctrl.sv -----
// Sequencer for the pending-interest table: clearing pass, table sweep and result hand-off.
// Depends on pit_pkg.
module pit_ctrl #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  pit_pkg::cmd_type             req_command,
   output logic                         req_stall,
   input  pit_pkg::pit_stat_type        stat,
   output pit_pkg::pit_cmd_type         cmd,
   output logic [$clog2(TABLE_ENTRIES)-1:0] addr
);

   localparam int IdxW = $clog2(TABLE_ENTRIES);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] addr_ff, addr_in;

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LastIdx) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            addr_in = '0;
            if (req_valid && req_command != pit_pkg::CMD_UNKNOWN) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LastIdx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      cmd.clear  = (state_ff == ST_CLEAR);
      cmd.load   = (state_ff == ST_IDLE) && req_valid
                   && (req_command != pit_pkg::CMD_UNKNOWN);
      cmd.rd     = (state_ff == ST_SWEEP);
      cmd.finish = (state_ff == ST_FINISH) && stat.out_free;
      addr       = addr_ff;
   end

endmodule

// ----- rtl/core/pit_dpath.sv -----
// Datapath of the pending-interest table: entry memory, sweep compare, result register.
// Depends on pit_pkg.
module pit_dpath #(
   parameter int TABLE_ENTRIES = 64,
   parameter int FACE_COUNT    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pit_pkg::pit_cmd_type         cmd,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] addr,
   output pit_pkg::pit_stat_type        stat,
   input  pit_pkg::pit_req_type         req_data,
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_index,
   input  logic [15:0]                  csr_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output pit_pkg::pit_rsp_type         rsp_data
);

   localparam int IdxW = $clog2(TABLE_ENTRIES);
   localparam logic [7:0] FaceBits = (FACE_COUNT >= 8) ? 8'hFF
                                   : 8'((1 << FACE_COUNT) - 1);

   pit_pkg::pit_entry_type mem [TABLE_ENTRIES];

   logic [15:0] lcid_ff, timeout_ff, time_ff;
   logic [7:0]  dmask_ff;

   pit_pkg::pit_req_type   item_ff;
   pit_pkg::pit_entry_type rd_data_ff, hit_ent_ff;
   logic                   rd_vld_ff, hit_ff, free_ff;
   logic [IdxW-1:0]        rd_idx_ff, hit_idx_ff, free_idx_ff;

   pit_pkg::pit_rsp_type   rsp_ff, rsp_in;
   logic                   rsp_valid_ff;

   logic                   wr_en;
   logic [IdxW-1:0]        wr_addr;
   pit_pkg::pit_entry_type wr_data;
   logic                   match, expired;
   logic [15:0]            age;
   logic [7:0]             face_bit, fwd;

   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcid_ff    <= '0;
         dmask_ff   <= 8'hFF;
         timeout_ff <= 16'd4;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pit_pkg::CSR_LOCAL_ID: lcid_ff    <= csr_wdata;
            pit_pkg::CSR_DEF_MASK: dmask_ff   <= csr_wdata[7:0];
            pit_pkg::CSR_TIMEOUT:  timeout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      age      = time_ff - rd_data_ff.stamp;
      match    = rd_data_ff.valid && (rd_data_ff.content == item_ff.content_id);
      expired  = rd_data_ff.valid && (age > timeout_ff);
      face_bit = item_ff.from_local ? 8'd0
               : ((8'd1 << item_ff.arrival_face) & FaceBits);
      fwd      = dmask_ff & FaceBits & ~face_bit;
   end

   // Result and table writes: clearing, tick purges, and at most one write at the end.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = '0;
      rsp_in  = '{action: pit_pkg::ACT_TICK, face_mask: 8'd0, local_deliver: 1'b0};
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = addr;
      end else if (rd_vld_ff) begin
         wr_en = (item_ff.command == pit_pkg::CMD_TICK) && expired;
      end else if (cmd.finish) begin
         unique case (item_ff.command)
            pit_pkg::CMD_INTEREST: begin
               if (hit_ff) begin
                  wr_en              = 1'b1;
                  wr_addr            = hit_idx_ff;
                  wr_data            = hit_ent_ff;
                  wr_data.faces      = hit_ent_ff.faces | face_bit;
                  wr_data.local_flag = hit_ent_ff.local_flag | item_ff.from_local;
                  wr_data.stamp      = time_ff;
                  rsp_in.action      = pit_pkg::ACT_AGGREGATED;
               end else if (!free_ff) begin
                  rsp_in.action = pit_pkg::ACT_FULL;
               end else if (item_ff.content_id == lcid_ff) begin
                  rsp_in.action        = pit_pkg::ACT_LOCAL;
                  rsp_in.face_mask     = face_bit;
                  rsp_in.local_deliver = item_ff.from_local;
               end else if (fwd == 8'd0) begin
                  rsp_in.action = pit_pkg::ACT_NO_ROUTE;
               end else begin
                  wr_en              = 1'b1;
                  wr_addr            = free_idx_ff;
                  wr_data.valid      = 1'b1;
                  wr_data.content    = item_ff.content_id;
                  wr_data.faces      = face_bit;
                  wr_data.local_flag = item_ff.from_local;
                  wr_data.stamp      = time_ff;
                  rsp_in.action      = pit_pkg::ACT_FORWARDED;
                  rsp_in.face_mask   = fwd;
               end
            end
            pit_pkg::CMD_DATA: begin
               if (hit_ff) begin
                  wr_en                = 1'b1;
                  wr_addr              = hit_idx_ff;
                  rsp_in.action        = pit_pkg::ACT_DELIVERED;
                  rsp_in.face_mask     = hit_ent_ff.faces;
                  rsp_in.local_deliver = hit_ent_ff.local_flag;
               end else begin
                  rsp_in.action = pit_pkg::ACT_UNSOLICIT;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd;
         if (cmd.load) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            if (req_data.command == pit_pkg::CMD_TICK) begin
               time_ff <= time_ff + 16'd1;
            end
         end else if (rd_vld_ff) begin
            if (match && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (!rd_data_ff.valid && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr;
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (rd_vld_ff && match && !hit_ff) begin
         hit_idx_ff <= rd_idx_ff;
         hit_ent_ff <= rd_data_ff;
      end
      if (rd_vld_ff && !rd_data_ff.valid && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/ccn_pending_interest_table.sv -----
// rsp_valid rises once an accepted interest, data or tick beat has been swept, one table
// entry per cycle from the memory port, and the finish state finds the result register free;
// req_stall stays high until then. A command of 3 is accepted while idle but gives no result.
// Reset: synchronous, active high; a clearing pass over every table entry follows, during
// which req_stall stays high. Configuration writes are taken at any time.
// Depends on pit_pkg, pit_ctrl and pit_dpath.
module ccn_pending_interest_table #(
   parameter int TABLE_ENTRIES = 64,
   parameter int FACE_COUNT    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pit_pkg::pit_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pit_pkg::pit_rsp_type  rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   // The controller walks an address counter over the table; the datapath reads one
   // entry per cycle, tracks the first matching and the first free entry, purges
   // expired entries on a tick, and writes back at most one entry when the beat ends.

   pit_pkg::pit_cmd_type  cmd;
   pit_pkg::pit_stat_type stat;
   logic [$clog2(TABLE_ENTRIES)-1:0] addr;

   pit_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_command(req_data.command),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd),
      .addr       (addr)
   );

   pit_dpath #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .FACE_COUNT   (FACE_COUNT)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .addr     (addr),
      .stat     (stat),
      .req_data (req_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

`ifndef SYNTH
   // The clearing pass must hold off input right after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not stalled during clearing pass");

   // A real command starts a sweep, so the next beat must wait.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.command != pit_pkg::CMD_UNKNOWN) |=> req_stall)
      else $error("input accepted during a sweep");

   // A result only appears at the end of a sweep.
   a_result_from_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a sweep");
`endif

endmodule

// ----- tb/tb_ccn_pending_interest_table.sv -----
// Self-checking testbench for the pending-interest table forwarding core.
// Depends on pit_pkg and ccn_pending_interest_table; a scoreboard class predicts each beat.
`timescale 1ns / 1ps

module tb_ccn_pending_interest_table;
   import pit_pkg::*;

   localparam int ENTRIES = 64;
   localparam int FACES = 8;
   localparam int CYCLE_LIMIT = 2000000;

   // Scoreboard: a private copy of the table, the registers and the clock of
   // ticks. note_request predicts the result of an accepted beat and queues it;
   // check_response compares one accepted result beat with the oldest one.
   class pit_scoreboard;
      logic          slot_valid [ENTRIES];
      logic [15:0]   slot_content [ENTRIES];
      logic [7:0]    slot_faces [ENTRIES];
      logic          slot_local [ENTRIES];
      logic [15:0]   slot_stamp [ENTRIES];
      logic [15:0]   tick_count;
      logic [15:0]   own_content_id;
      logic [7:0]    route_mask;
      logic [15:0]   age_limit;
      pit_rsp_type   pending_rsp [$];
      int            error_count;

      function new();
         for (int i = 0; i < ENTRIES; i++) release_slot(i);
         tick_count = '0;
         own_content_id = '0;
         route_mask = 8'hFF;
         age_limit = 16'd4;
         error_count = 0;
      endfunction

      function void release_slot(int i);
         slot_valid[i] = 1'b0;
         slot_content[i] = '0;
         slot_faces[i] = '0;
         slot_local[i] = 1'b0;
         slot_stamp[i] = '0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            CSR_LOCAL_ID: own_content_id = value;
            CSR_DEF_MASK: route_mask = value[7:0];
            CSR_TIMEOUT: age_limit = value;
            default: ;
         endcase
      endfunction

      function void note_request(pit_req_type req);
         pit_rsp_type rsp;
         int hit;
         int hole;
         logic [7:0] face_bit;
         logic [7:0] face_range;
         logic [7:0] out_mask;
         logic [15:0] age;
         rsp = '0;
         hit = -1;
         hole = -1;
         face_range = (FACES >= 8) ? 8'hFF : 8'((1 << FACES) - 1);
         face_bit = (8'd1 << req.arrival_face) & face_range;
         if (req.command == CMD_UNKNOWN) return;
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_content[i] == req.content_id) hit = i;
            if (!slot_valid[i]) hole = i;
         end
         case (req.command)
            CMD_INTEREST: begin
               if (hit >= 0) begin
                  if (req.from_local) slot_local[hit] = 1'b1;
                  else slot_faces[hit] |= face_bit;
                  slot_stamp[hit] = tick_count;
                  rsp.action = ACT_AGGREGATED;
               end else if (hole < 0) begin
                  rsp.action = ACT_FULL;
               end else if (req.content_id == own_content_id) begin
                  // Served here: answer the arrival at once, nothing stays in the table.
                  rsp.action = ACT_LOCAL;
                  rsp.face_mask = req.from_local ? 8'd0 : face_bit;
                  rsp.local_deliver = req.from_local;
               end else begin
                  out_mask = route_mask & face_range;
                  if (!req.from_local) out_mask &= ~face_bit;
                  if (out_mask == 0) begin
                     rsp.action = ACT_NO_ROUTE;
                  end else begin
                     rsp.action = ACT_FORWARDED;
                     rsp.face_mask = out_mask;
                     slot_valid[hole] = 1'b1;
                     slot_content[hole] = req.content_id;
                     slot_faces[hole] = req.from_local ? 8'd0 : face_bit;
                     slot_local[hole] = req.from_local;
                     slot_stamp[hole] = tick_count;
                  end
               end
            end
            CMD_DATA: begin
               if (hit >= 0) begin
                  rsp.action = ACT_DELIVERED;
                  rsp.face_mask = slot_faces[hit];
                  rsp.local_deliver = slot_local[hit];
                  release_slot(hit);
               end else begin
                  rsp.action = ACT_UNSOLICIT;
               end
            end
            default: begin
               tick_count = tick_count + 16'd1;
               for (int i = 0; i < ENTRIES; i++) begin
                  age = tick_count - slot_stamp[i];
                  if (slot_valid[i] && age > age_limit) release_slot(i);
               end
               rsp.action = ACT_TICK;
            end
         endcase
         pending_rsp = {pending_rsp, rsp};
      endfunction

      function void check_response(pit_rsp_type got);
         pit_rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            error_count++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.action !== want.action) begin
            $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
            error_count++;
         end
         if (got.face_mask !== want.face_mask) begin
            $display("%0t: face_mask expected %h actual %h", $time, want.face_mask,
                     got.face_mask);
            error_count++;
         end
         if (got.local_deliver !== want.local_deliver) begin
            $display("%0t: local_deliver expected %b actual %b", $time, want.local_deliver,
                     got.local_deliver);
            error_count++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   pit_req_type  req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   pit_rsp_type  rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   pit_scoreboard board = new();
   int           cycle_count = 0;
   // Long receiver hold-off, requested by the stimulus and counted by the receiver.
   int           hold_cycles = 0;

   // Small pool of content ids so that interests and data meet in the table.
   logic [15:0]  id_pool [16];

   always #4 clock = ~clock;

   ccn_pending_interest_table #(.TABLE_ENTRIES(ENTRIES), .FACE_COUNT(FACES)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Results are checked at the rising edge at which the beat is accepted.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ccn_pending_interest_table regression: fail");
         $finish;
      end
   end

   // Receiver: a random stall before each result beat, with stretches of none, and a long
   // hold-off whenever the stimulus asks for one.
   initial begin : receiver
      int gap;
      @(negedge clock);
      while (1) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (hold_cycles > 0) begin
            gap = gap + hold_cycles;
            hold_cycles = 0;
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Offers one request beat after a gap, holding it until accepted. Valid stays
   // high afterwards so that a beat with no gap follows directly.
   task automatic send_request(pit_req_type req, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(req);
      @(negedge clock);
   endtask

   task automatic send_quick(logic [1:0] cmd, logic [15:0] cid, logic [2:0] face,
                             logic from_app);
      pit_req_type req;
      req.command = cmd_type'(cmd);
      req.content_id = cid;
      req.arrival_face = face;
      req.from_local = from_app;
      send_request(req, $urandom_range(0, 2));
   endtask

   // Waits until every predicted result has come, plus the sweep of one beat.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(negedge clock);
      repeat (ENTRIES + 10) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.write_reg(idx, value);
      @(negedge clock);
   endtask

   // Random request: mostly interests and data on pooled ids, some ticks, noise.
   function automatic pit_req_type random_request();
      pit_req_type req;
      int pick;
      pick = $urandom_range(0, 99);
      req.command = (pick < 50) ? CMD_INTEREST : (pick < 82) ? CMD_DATA :
                    (pick < 97) ? CMD_TICK : CMD_UNKNOWN;
      req.content_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                       id_pool[$urandom_range(0, 15)];
      req.arrival_face = 3'($urandom_range(0, 7));
      req.from_local = ($urandom_range(0, 4) == 0);
      return req;
   endfunction

   task automatic random_phase(int count);
      int gap;
      for (int n = 0; n < count; n++) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if ((n / 40) % 3 == 2) gap = 0;
         send_request(random_request(), gap);
      end
   endtask

   initial begin : stimulus
      logic [15:0] cfg_timeout [4];
      logic [7:0]  cfg_mask [4];
      for (int i = 0; i < 16; i++) id_pool[i] = 16'($urandom);
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset settings: local id 0, full route, timeout 4.
      send_quick(CMD_INTEREST, 16'h0000, 3'd7, 1'b0);     // local reply to a face
      send_quick(CMD_INTEREST, 16'h0000, 3'd0, 1'b1);     // local reply to the app
      send_quick(CMD_INTEREST, 16'hFFFF, 3'd0, 1'b0);     // forwarded
      send_quick(CMD_INTEREST, 16'hFFFF, 3'd7, 1'b0);     // aggregated, second face
      send_quick(CMD_INTEREST, 16'hFFFF, 3'd3, 1'b1);     // aggregated from the app
      send_quick(CMD_DATA, 16'hFFFF, 3'd1, 1'b0);         // delivered with local
      send_quick(CMD_DATA, 16'hFFFF, 3'd1, 1'b0);         // now unsolicited
      send_quick(CMD_UNKNOWN, 16'h1234, 3'd5, 1'b1);      // no result
      send_quick(CMD_INTEREST, 16'h5A5A, 3'd2, 1'b1);     // forwarded on all faces
      for (int t = 0; t < 6; t++) send_quick(CMD_TICK, 16'h0, 3'd0, 1'b0);  // expiry
      send_quick(CMD_DATA, 16'h5A5A, 3'd0, 1'b0);         // expired, unsolicited
      drain_results();

      // Only face 4 on the route: a beat arriving on face 4 has no route.
      write_csr(CSR_DEF_MASK, 16'h0010);
      write_csr(CSR_LOCAL_ID, 16'hFFFF);
      write_csr(CSR_TIMEOUT, 16'd65535);
      send_quick(CMD_INTEREST, 16'h0101, 3'd4, 1'b0);     // no route drop
      send_quick(CMD_INTEREST, 16'hFFFF, 3'd4, 1'b0);     // local reply
      send_quick(CMD_INTEREST, 16'h0101, 3'd1, 1'b0);     // forwarded on face 4
      drain_results();

      // Fill the table to see the full case, then free it again.
      write_csr(CSR_DEF_MASK, 16'h0000);
      write_csr(CSR_DEF_MASK, 16'h00FF);
      for (int i = 0; i < ENTRIES + 2; i++) send_quick(CMD_INTEREST, 16'(16'h0200 + i),
                                                       3'(i), 1'b0);
      send_quick(CMD_INTEREST, 16'hFFFF, 3'd0, 1'b0);     // full even though local
      for (int i = 0; i < ENTRIES; i++) send_quick(CMD_DATA, 16'(16'h0200 + i), 3'd0, 1'b0);
      drain_results();

      // Random phases across settings, the extremes among them.
      cfg_timeout = '{16'd1, 16'd3, 16'd12, 16'd65535};
      cfg_mask = '{8'h00, 8'h81, 8'hFF, 8'h5A};
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_TIMEOUT, cfg_timeout[ph]);
         write_csr(CSR_DEF_MASK, {8'h00, cfg_mask[ph]});
         write_csr(CSR_LOCAL_ID, id_pool[$urandom_range(0, 15)]);
         if (ph == 1) begin
            // The receiver holds off while the sender keeps offering beats.
            hold_cycles = 2000;
            random_phase(40);
         end
         random_phase(420);
         // The sender waits until everything has come before the registers change.
         drain_results();
      end
      drain_results();
      if (board.error_count == 0) begin
         $display("ccn_pending_interest_table regression: pass");
      end else begin
         $display("ccn_pending_interest_table regression: fail");
      end
      $finish;
   end

endmodule
